/* sv/gtsc_pkg.sv */
// Shared types, microcode codes and the control store of the gcd core.
`default_nettype none
package gtsc_pkg;

  localparam int StepBits = 3;
  localparam int OpBits   = 3;
  localparam int CondBits = 3;

  localparam logic [OpBits-1:0] OP_NOP     = 3'd0;
  localparam logic [OpBits-1:0] OP_LOAD    = 3'd1;
  localparam logic [OpBits-1:0] OP_DIVINIT = 3'd2;
  localparam logic [OpBits-1:0] OP_DIVSTEP = 3'd3;
  localparam logic [OpBits-1:0] OP_ACC     = 3'd4;
  localparam logic [OpBits-1:0] OP_SWAP    = 3'd5;
  localparam logic [OpBits-1:0] OP_FIN     = 3'd6;
  localparam logic [OpBits-1:0] OP_OUT     = 3'd7;

  localparam logic [CondBits-1:0] COND_NONE          = 3'd0;
  localparam logic [CondBits-1:0] COND_ALWAYS        = 3'd1;
  localparam logic [CondBits-1:0] COND_NOT_IN_VALID  = 3'd2;
  localparam logic [CondBits-1:0] COND_ERR           = 3'd3;
  localparam logic [CondBits-1:0] COND_NOT_DIV_LAST  = 3'd4;
  localparam logic [CondBits-1:0] COND_REM_ZERO      = 3'd5;
  localparam logic [CondBits-1:0] COND_NOT_OUT_READY = 3'd6;

  localparam logic [StepBits-1:0] STEP_WAIT    = 3'd0;
  localparam logic [StepBits-1:0] STEP_CHECK   = 3'd1;
  localparam logic [StepBits-1:0] STEP_DIVINIT = 3'd2;
  localparam logic [StepBits-1:0] STEP_DIVSTEP = 3'd3;
  localparam logic [StepBits-1:0] STEP_ACC     = 3'd4;
  localparam logic [StepBits-1:0] STEP_SWAP    = 3'd5;
  localparam logic [StepBits-1:0] STEP_FIN     = 3'd6;
  localparam logic [StepBits-1:0] STEP_OUT     = 3'd7;

  typedef struct packed {
    logic [OpBits-1:0]   op;
    logic [CondBits-1:0] cond;
    logic [StepBits-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic err;
    logic div_last;
    logic rem_zero;
  } dp_status_t;

  function automatic ctrl_word_t control_store(input logic [StepBits-1:0] step);
    ctrl_word_t cw;
    case (step)
      STEP_WAIT:    cw = '{op: OP_LOAD,    cond: COND_NOT_IN_VALID,  target: STEP_WAIT};
      STEP_CHECK:   cw = '{op: OP_NOP,     cond: COND_ERR,           target: STEP_FIN};
      STEP_DIVINIT: cw = '{op: OP_DIVINIT, cond: COND_NONE,          target: STEP_WAIT};
      STEP_DIVSTEP: cw = '{op: OP_DIVSTEP, cond: COND_NOT_DIV_LAST,  target: STEP_DIVSTEP};
      STEP_ACC:     cw = '{op: OP_ACC,     cond: COND_REM_ZERO,      target: STEP_FIN};
      STEP_SWAP:    cw = '{op: OP_SWAP,    cond: COND_ALWAYS,        target: STEP_DIVINIT};
      STEP_FIN:     cw = '{op: OP_FIN,     cond: COND_NONE,          target: STEP_WAIT};
      STEP_OUT:     cw = '{op: OP_OUT,     cond: COND_NOT_OUT_READY, target: STEP_OUT};
      default:      cw = '{op: OP_NOP,     cond: COND_ALWAYS,        target: STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

/* sv/gtsc_if.sv */
// Valid/ready channel interfaces for the operand and result streams.
`default_nettype none
interface gtsc_op_if #(parameter int W = 31);
  logic         valid;
  logic         ready;
  logic [W-1:0] first_operand;
  logic [W-1:0] second_operand;
  modport source (output valid, first_operand, second_operand, input ready);
  modport sink (input valid, first_operand, second_operand, output ready);
endinterface

interface gtsc_res_if #(parameter int W = 31);
  logic         valid;
  logic         ready;
  logic [W-1:0] divisor;
  logic [W-2:0] trial_steps;
  logic [W-1:0] subtract_steps;
  logic         error;
  modport source (output valid, divisor, trial_steps, subtract_steps, error, input ready);
  modport sink (input valid, divisor, trial_steps, subtract_steps, error, output ready);
endinterface
`default_nettype wire

/* sv/gtsc_seq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module gtsc_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gtsc_pkg::dp_status_t status,
  input  wire logic                in_valid,
  input  wire logic                out_ready,
  output gtsc_pkg::ctrl_word_t     cw
);
  import gtsc_pkg::*;

  logic [StepBits-1:0] step;
  logic [StepBits-1:0] step_next;
  logic                take;

  assign cw = control_store(step);

  always_comb begin
    case (cw.cond)
      COND_NONE:          take = 1'b0;
      COND_ALWAYS:        take = 1'b1;
      COND_NOT_IN_VALID:  take = !in_valid;
      COND_ERR:           take = status.err;
      COND_NOT_DIV_LAST:  take = !status.div_last;
      COND_REM_ZERO:      take = status.rem_zero;
      COND_NOT_OUT_READY: take = !out_ready;
      default:            take = 1'b0;
    endcase
    step_next = take ? cw.target : step + StepBits'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end
endmodule
`default_nettype wire

/* sv/gtsc_dp.sv */
// Datapath: operand registers, bit-serial divider, quotient sum and result registers.
`default_nettype none
module gtsc_dp #(
  parameter int W = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire gtsc_pkg::ctrl_word_t cw,
  input  wire logic                 load,
  input  wire logic [W-1:0]         first_operand,
  input  wire logic [W-1:0]         second_operand,
  output gtsc_pkg::dp_status_t      status,
  output logic [W-1:0]              divisor,
  output logic [W-2:0]              trial_steps,
  output logic [W-1:0]              subtract_steps,
  output logic                      error
);
  import gtsc_pkg::*;

  localparam int CntBits = $clog2(W);

  logic [W-1:0]       big;
  logic [W-1:0]       small_op;
  logic [W-1:0]       rem;
  logic [W-1:0]       quot;
  logic [W-1:0]       count;
  logic [W-2:0]       lo_half;
  logic [CntBits-1:0] bitcnt;
  logic               err;
  logic               first;
  logic               exact;

  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] trial_full;

  assign rem_sh     = {rem, quot[W-1]};
  assign diff       = rem_sh - {1'b0, small_op};
  assign fits       = !diff[W];
  assign trial_full = {1'b0, lo_half} - small_op + W'(1);

  assign status.err      = err;
  assign status.div_last = (bitcnt == '0);
  assign status.rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      err   <= 1'b0;
      first <= 1'b0;
      exact <= 1'b0;
    end else begin
      case (cw.op)
        OP_LOAD: begin
          if (load) begin
            err   <= (first_operand == '0) || (second_operand == '0);
            first <= 1'b1;
            exact <= 1'b0;
          end
        end
        OP_ACC: begin
          if (first) begin
            exact <= (rem == '0);
          end
          first <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (load) begin
          if (first_operand < second_operand) begin
            big      <= second_operand;
            small_op <= first_operand;
            lo_half  <= first_operand[W-1:1];
          end else begin
            big      <= first_operand;
            small_op <= second_operand;
            lo_half  <= second_operand[W-1:1];
          end
          count <= '0;
        end
      end
      OP_DIVINIT: begin
        rem    <= '0;
        quot   <= big;
        bitcnt <= CntBits'(W - 1);
      end
      OP_DIVSTEP: begin
        rem    <= fits ? diff[W-1:0] : rem_sh[W-1:0];
        quot   <= {quot[W-2:0], fits};
        bitcnt <= bitcnt - CntBits'(1);
      end
      OP_ACC: begin
        count <= count + quot;
      end
      OP_SWAP: begin
        big      <= small_op;
        small_op <= rem;
      end
      OP_FIN: begin
        error <= err;
        if (err) begin
          divisor        <= '0;
          trial_steps    <= '0;
          subtract_steps <= '0;
        end else begin
          divisor        <= small_op;
          trial_steps    <= exact ? '0 : trial_full[W-2:0];
          subtract_steps <= count - W'(1);
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

/* sv/gcd_trial_and_subtractive_core.sv */
// Top level of the gcd core: trial-division count and subtractive Euclid count.
//
//  Channel   Dir  Handshake     Payload
//  operands  in   valid/ready   first_operand, second_operand
//  results   out  valid/ready   divisor, trial_steps, subtract_steps, error
//
// One transfer is taken at a time; the next operand pair is accepted after the result is taken.
// Each Euclid round runs the shared divider one quotient bit per cycle, one round per division
// step of the pair; a zero operand skips the rounds and goes straight to the result.
// The round count is at most 44 for 31-bit operands, which sets the worst case.
// Synchronous rst returns the sequencer to its wait step; a stalled result holds its registers.
`default_nettype none
module gcd_trial_and_subtractive_core #(
  parameter int OPERAND_BITS = 31
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gtsc_op_if.sink    operands,
  gtsc_res_if.source results
);
  import gtsc_pkg::*;

  ctrl_word_t cw;
  dp_status_t status;
  logic       load;

  assign operands.ready = (cw.op == OP_LOAD);
  assign results.valid  = (cw.op == OP_OUT);
  assign load           = operands.valid && operands.ready;

  gtsc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .in_valid  (operands.valid),
    .out_ready (results.ready),
    .cw        (cw)
  );

  gtsc_dp #(
    .W (OPERAND_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cw             (cw),
    .load           (load),
    .first_operand  (operands.first_operand),
    .second_operand (operands.second_operand),
    .status         (status),
    .divisor        (results.divisor),
    .trial_steps    (results.trial_steps),
    .subtract_steps (results.subtract_steps),
    .error          (results.error)
  );
endmodule
`default_nettype wire
